### src/wbcs_pkg.sv
// ----------------------------------------------------------------------------
// wbcs_pkg: shared types and constants
// Payload structs, command codes, register indexes and widths for the white
// blob centroid steering block.
// ----------------------------------------------------------------------------
package wbcs_pkg;

    localparam int DIM_W   = 13;
    localparam int COL_W   = 12;
    localparam int IDX_W   = 24;
    localparam int CNT_W   = 24;
    localparam int SUM_W   = 37;
    localparam int CFG_IDX_W = 8;

    localparam int DEF_MAX_DIMENSION = 4096;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Multiply by THIRD_RECIP and shift right by THIRD_SHIFT gives floor(x/3)
    // for any 16-bit x.
    localparam logic [15:0] THIRD_RECIP = 16'hAAAB;
    localparam int          THIRD_SHIFT = 17;

    typedef enum logic [1:0] {
        CMD_STOP    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_LEFT    = 2'd2,
        CMD_RIGHT   = 2'd3
    } t_drive_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        t_drive_cmd        drive_command;
        logic [COL_W-1:0]  centroid_column;
        logic [CNT_W-1:0]  white_count;
    } t_result;

    typedef struct packed {
        logic pix_accept;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
    } t_dp_sts;

endpackage

### src/wbcs_ctrl.sv
// ----------------------------------------------------------------------------
// wbcs_ctrl: frame controller
// Sequences pixel accumulation, the end-of-frame division and the hand-off of
// the result to the output register.
// ----------------------------------------------------------------------------
module wbcs_ctrl
    import wbcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_LOAD
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              slot_free;

    assign slot_free        = !r_out_valid || !i_out_stall;
    assign o_in_stall       = (r_state != S_RUN);
    assign o_out_valid      = r_out_valid;
    assign o_cmd.pix_accept = i_in_valid && (r_state == S_RUN);
    assign o_cmd.div_step   = (r_state == S_DIV);
    assign o_cmd.out_load   = (r_state == S_LOAD) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (o_cmd.pix_accept && i_sts.frame_end) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_LOAD: begin
                    if (slot_free) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase

            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### src/wbcs_dp.sv
// ----------------------------------------------------------------------------
// wbcs_dp: accumulation and division datapath
// Holds the image size registers, the per-frame counters, a restoring divider
// for the centroid and the result register.
// ----------------------------------------------------------------------------
module wbcs_dp
    import wbcs_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  t_pixel               i_pixel,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_result              o_result
);

    localparam int AREA_W = 2 * DIM_W;
    localparam int PW     = DIM_W + 16 + 2;

    logic [DIM_W-1:0]  r_cfg_width;
    logic [DIM_W-1:0]  r_cfg_height;
    logic [IDX_W-1:0]  r_pidx;
    logic [COL_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div_total;
    t_result           r_out;

    logic [DIM_W-1:0]  w_dim;
    logic [DIM_W-1:0]  h_dim;
    logic [AREA_W-1:0] area;
    logic [AREA_W:0]   p3;
    logic              in_band;
    logic              counted;
    logic [CNT_W-1:0]  total_next;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_next;
    logic [DIM_W:0]    col_inc;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic [PW-1:0]     prod_lo;
    logic [PW-1:0]     prod_hi;
    logic [SUM_W-1:0]  thr_lo;
    logic [SUM_W-1:0]  thr_hi;
    t_drive_cmd        drive;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_DIMENSION)) begin
            w_dim = DIM_W'(MAX_DIMENSION);
        end else begin
            w_dim = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (32'(r_cfg_height) > 32'(MAX_DIMENSION)) begin
            h_dim = DIM_W'(MAX_DIMENSION);
        end else begin
            h_dim = r_cfg_height;
        end
    end

    assign area    = AREA_W'(w_dim) * AREA_W'(h_dim);
    assign p3      = (AREA_W+1)'({r_pidx, 1'b0}) + (AREA_W+1)'(r_pidx);
    assign in_band = (p3 >= {1'b0, area}) && (p3 < {area, 1'b0});
    assign counted = (&{i_pixel.red, i_pixel.green, i_pixel.blue}) && in_band;

    assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_col);

    always_comb begin
        total_next = r_total;
        sum_next   = r_sum;
        if (counted) begin
            if (r_total != '1) begin
                total_next = r_total + CNT_W'(1);
            end
            sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        end
    end

    assign col_inc = (DIM_W+1)'(r_col) + (DIM_W+1)'(1);

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign q_bit = (trial >= {1'b0, r_div_total});

    assign prod_lo = PW'(w_dim) * PW'(THIRD_RECIP);
    assign prod_hi = PW'({w_dim, 1'b0}) * PW'(THIRD_RECIP);
    assign thr_lo  = SUM_W'(prod_lo >> THIRD_SHIFT);
    assign thr_hi  = SUM_W'(prod_hi >> THIRD_SHIFT);

    always_comb begin
        if (r_div_total == '0) begin
            drive = CMD_STOP;
        end else if (r_quo < thr_lo) begin
            drive = CMD_LEFT;
        end else if (r_quo > thr_hi) begin
            drive = CMD_RIGHT;
        end else begin
            drive = CMD_FORWARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_pidx       <= '0;
            r_col        <= '0;
            r_total      <= '0;
            r_sum        <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    r_cfg_width <= i_cfg_data;
                end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                    r_cfg_height <= i_cfg_data;
                end
            end
            if (i_cmd.pix_accept) begin
                if (i_pixel.frame_end) begin
                    r_pidx  <= '0;
                    r_col   <= '0;
                    r_total <= '0;
                    r_sum   <= '0;
                end else begin
                    r_total <= total_next;
                    r_sum   <= sum_next;
                    if (r_pidx != '1) begin
                        r_pidx <= r_pidx + IDX_W'(1);
                    end
                    if (col_inc >= (DIM_W+1)'(w_dim)) begin
                        r_col <= '0;
                    end else begin
                        r_col <= col_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_accept && i_pixel.frame_end) begin
            r_quo       <= sum_next;
            r_rem       <= '0;
            r_div_total <= total_next;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= CNT_W'(trial - {1'b0, r_div_total});
            end else begin
                r_rem <= trial[CNT_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.drive_command   <= drive;
            r_out.centroid_column <= (r_div_total == '0) ? '0 : r_quo[COL_W-1:0];
            r_out.white_count     <= r_div_total;
        end
    end

    assign o_sts.frame_end = i_pixel.frame_end;
    assign o_result        = r_out;

endmodule

### src/white_blob_centroid_steering.sv
// ----------------------------------------------------------------------------
// white_blob_centroid_steering: steering from the centroid of white pixels
// Pixels arrive one per cycle in raster order while the input is not
// stalled; an ordinary pixel does not stall the input. The pixel that ends
// a frame starts a bit-serial restoring division of the column sum by the
// white count, one quotient bit per cycle, and the result is then placed in
// the output register; the input stays stalled from that pixel through the
// division and the load, longer only if the previous result has still not
// been taken. Register writes are held off while the input is stalled. The
// next frame may stream while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module white_blob_centroid_steering
    import wbcs_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pixel               i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = !o_in_stall;

    wbcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    wbcs_dp #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_out_data)
    );

endmodule
